// ===== design/pidh_pkg.sv =====
// Shared constants, types and register codes of the periodic-image density histogram.
// Depends on nothing; pidh_front, pidh_back, pidh_store and the top level import it.
`default_nettype none
package pidh_pkg;
    localparam int DIM_X       = 32;
    localparam int DIM_Y       = 32;
    localparam int DIM_Z       = 16;
    localparam int NUM_KINDS   = 4;
    localparam int IMAGE_REACH = 2;
    localparam int PLANE       = DIM_X * DIM_Y * DIM_Z;
    localparam int TOTAL_BINS  = NUM_KINDS * PLANE;
    localparam int STORE_DEPTH = 65536;
    localparam int ADDR_W      = 16;
    localparam int CNT_W       = 24;
    localparam int BIN_W       = 10;
    localparam int OFF_W       = 3;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = 2;
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    localparam logic [2:0] CFG_LAT_A     = 3'd0;
    localparam logic [2:0] CFG_LAT_B     = 3'd1;
    localparam logic [2:0] CFG_LAT_C     = 3'd2;
    localparam logic [2:0] CFG_WIN_LOW   = 3'd3;
    localparam logic [2:0] CFG_WIN_HIGH  = 3'd4;
    localparam logic [2:0] CFG_BIN_SCALE = 3'd5;

    typedef enum logic {CMD_ADD = 1'b0, CMD_READ = 1'b1} cmd_t;

    typedef struct packed {
        cmd_t               cmd;
        logic signed [23:0] frac_x;
        logic signed [23:0] frac_y;
        logic signed [23:0] frac_z;
        logic [1:0]         atom_kind;
        logic [15:0]        read_index;
    } item_t;

    typedef struct packed {
        logic [62:0] lat_a;
        logic [62:0] lat_b;
        logic [62:0] lat_c;
        logic [62:0] win_low;
        logic [62:0] win_high;
        logic [59:0] scale;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
    } upd_t;

    typedef struct packed {
        logic              valid;
        logic              out_of_range;
        logic [ADDR_W-1:0] addr;
    } rd_req_t;
endpackage
`default_nettype wire

// ===== design/pidh_front.sv =====
// Front end: input item queue between the port and the back end.
// Depends on pidh_pkg.
`default_nettype none
module pidh_front
    import pidh_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  enable,
    input  wire logic  push_valid,
    output logic       push_ready,
    input  wire item_t push_item,
    output logic       head_valid,
    output item_t      head_item,
    input  wire logic  pop
);
    item_t                  q_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]       count_reg, count_next;
    logic                   do_push, do_pop;

    assign push_ready = enable && (count_reg < (FIFO_AW+1)'(FIFO_DEPTH));
    assign do_push    = push_valid && push_ready;
    assign head_valid = (count_reg != '0);
    assign head_item  = q_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            q_reg[wr_ptr_reg] <= push_item;
        end
    end
endmodule
`default_nettype wire

// ===== design/pidh_back.sv =====
// Back end: image sequencer and transform/binning pipeline; issues bin reads.
// Depends on pidh_pkg.
`default_nettype none
module pidh_back
    import pidh_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire cfg_t  cfg,
    input  wire logic  head_valid,
    input  wire item_t head_item,
    output logic       pop,
    input  wire logic  out_busy,
    output rd_req_t    rd_req,
    output upd_t       upd
);
    typedef enum logic [1:0] {ST_IDLE = 2'b01, ST_ADD = 2'b10} state_t;

    state_t state_reg, state_next;
    logic signed [OFF_W-1:0] ix_reg, ix_next, iy_reg, iy_next, iz_reg, iz_next;
    logic signed [23:0] fx_reg, fy_reg, fz_reg;
    logic [1:0]         kind_reg;
    logic               load_atom, emit, last_image, pipe_busy;

    localparam logic signed [OFF_W-1:0] REACH_P = OFF_W'(IMAGE_REACH);
    localparam logic signed [OFF_W-1:0] REACH_N = -OFF_W'(IMAGE_REACH);

    // Pipeline registers
    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic [1:0]         s1_kind_reg, s2_kind_reg, s3_kind_reg, s4_kind_reg;
    logic signed [26:0] s1_f_reg [3];
    logic signed [47:0] s2_p_reg [3][3];
    logic [28:0]        s3_diff_reg [3];
    logic [26:0]        s4_bin_reg [3];
    upd_t               upd_reg;
    // Update still in the store's read-modify-write
    logic               st_pend_reg;

    logic signed [20:0] lat [3][3];
    logic signed [27:0] lo [3], hi [3];
    logic [19:0]        sc [3];
    logic signed [26:0] f_next [3];
    logic signed [47:0] p_next [3][3];
    logic signed [49:0] sum [3];
    logic signed [27:0] pos [3];
    logic [28:0]        diff_next [3];
    logic [48:0]        prod [3];
    logic [26:0]        bin_next [3];
    logic [2:0]         in_win;
    logic [BIN_W-1:0]   bx, by, bz;
    logic [31:0]        flat;

    assign last_image = (ix_reg == REACH_P) && (iy_reg == REACH_P) && (iz_reg == REACH_P);
    assign emit       = (state_reg == ST_ADD);
    assign pipe_busy  = s1_valid_reg || s2_valid_reg || s3_valid_reg || s4_valid_reg
                        || upd_reg.valid || st_pend_reg;

    always_comb begin
        state_next = state_reg;
        ix_next    = ix_reg;
        iy_next    = iy_reg;
        iz_next    = iz_reg;
        pop        = 1'b0;
        load_atom  = 1'b0;
        rd_req     = '0;
        case (state_reg)
            ST_IDLE: begin
                if (head_valid) begin
                    if (head_item.cmd == CMD_READ) begin
                        if (!pipe_busy && !out_busy) begin
                            pop                 = 1'b1;
                            rd_req.valid        = 1'b1;
                            rd_req.addr         = head_item.read_index;
                            rd_req.out_of_range =
                                (32'(head_item.read_index) >= 32'(TOTAL_BINS));
                        end
                    end else begin
                        pop = 1'b1;
                        if (32'(head_item.atom_kind) < 32'(NUM_KINDS)) begin
                            load_atom  = 1'b1;
                            ix_next    = REACH_N;
                            iy_next    = REACH_N;
                            iz_next    = REACH_N;
                            state_next = ST_ADD;
                        end
                    end
                end
            end
            ST_ADD: begin
                if (last_image) begin
                    state_next = ST_IDLE;
                end else if (iz_reg != REACH_P) begin
                    iz_next = iz_reg + 1'b1;
                end else begin
                    iz_next = REACH_N;
                    if (iy_reg != REACH_P) begin
                        iy_next = iy_reg + 1'b1;
                    end else begin
                        iy_next = REACH_N;
                        ix_next = ix_reg + 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        ix_reg <= ix_next;
        iy_reg <= iy_next;
        iz_reg <= iz_next;
        if (load_atom) begin
            fx_reg   <= head_item.frac_x;
            fy_reg   <= head_item.frac_y;
            fz_reg   <= head_item.frac_z;
            kind_reg <= head_item.atom_kind;
        end
    end

    // Unpack the configuration fields
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            lat[0][a] = cfg.lat_a[21*a +: 21];
            lat[1][a] = cfg.lat_b[21*a +: 21];
            lat[2][a] = cfg.lat_c[21*a +: 21];
            lo[a]     = {{7{cfg.win_low[21*a+20]}}, cfg.win_low[21*a +: 21]};
            hi[a]     = {{7{cfg.win_high[21*a+20]}}, cfg.win_high[21*a +: 21]};
            sc[a]     = cfg.scale[20*a +: 20];
        end
    end

    // Image coordinate: frac plus offset in whole cells
    assign f_next[0] = {{3{fx_reg[23]}}, fx_reg} + {{4{ix_reg[2]}}, ix_reg, 20'd0};
    assign f_next[1] = {{3{fy_reg[23]}}, fy_reg} + {{4{iy_reg[2]}}, iy_reg, 20'd0};
    assign f_next[2] = {{3{fz_reg[23]}}, fz_reg} + {{4{iz_reg[2]}}, iz_reg, 20'd0};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int a = 0; a < 3; a++) begin
                p_next[i][a] = s1_f_reg[i] * lat[i][a];
            end
        end
        for (int a = 0; a < 3; a++) begin
            sum[a] = {{2{s2_p_reg[0][a][47]}}, s2_p_reg[0][a]}
                   + {{2{s2_p_reg[1][a][47]}}, s2_p_reg[1][a]}
                   + {{2{s2_p_reg[2][a][47]}}, s2_p_reg[2][a]};
            // Dropping the low bits of a two's complement value floors it
            pos[a]       = sum[a][49:22];
            in_win[a]    = (pos[a] >= lo[a]) && (pos[a] <= hi[a]);
            diff_next[a] = {pos[a][27], pos[a]} - {lo[a][27], lo[a]};
            prod[a]      = 49'(s3_diff_reg[a]) * 49'(sc[a]);
            bin_next[a]  = prod[a][48:22];
        end
        bx = (s4_bin_reg[0] >= 27'(DIM_X)) ? BIN_W'(DIM_X - 1) : s4_bin_reg[0][BIN_W-1:0];
        by = (s4_bin_reg[1] >= 27'(DIM_Y)) ? BIN_W'(DIM_Y - 1) : s4_bin_reg[1][BIN_W-1:0];
        bz = (s4_bin_reg[2] >= 27'(DIM_Z)) ? BIN_W'(DIM_Z - 1) : s4_bin_reg[2][BIN_W-1:0];
        flat = 32'(s4_kind_reg) * 32'(PLANE)
             + (32'(bx) * 32'(DIM_Y) + 32'(by)) * 32'(DIM_Z) + 32'(bz);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            upd_reg.valid <= 1'b0;
            st_pend_reg   <= 1'b0;
        end else begin
            s1_valid_reg  <= emit;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg && in_win[0] && in_win[1] && in_win[2];
            s4_valid_reg  <= s3_valid_reg;
            upd_reg.valid <= s4_valid_reg && (flat < 32'(STORE_DEPTH));
            st_pend_reg   <= upd_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        s1_kind_reg <= kind_reg;
        s2_kind_reg <= s1_kind_reg;
        s3_kind_reg <= s2_kind_reg;
        s4_kind_reg <= s3_kind_reg;
        for (int a = 0; a < 3; a++) begin
            s1_f_reg[a]    <= f_next[a];
            s3_diff_reg[a] <= diff_next[a];
            s4_bin_reg[a]  <= bin_next[a];
            for (int i = 0; i < 3; i++) begin
                s2_p_reg[i][a] <= p_next[i][a];
            end
        end
        upd_reg.addr <= flat[ADDR_W-1:0];
    end

    assign upd = upd_reg;
endmodule
`default_nettype wire

// ===== design/pidh_store.sv =====
// Bin count memory: clearing pass, saturating read-modify-write, bin reads.
// Depends on pidh_pkg.
`default_nettype none
module pidh_store
    import pidh_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire upd_t    upd,
    input  wire rd_req_t rd_req,
    output logic         clearing,
    output logic         rd_done,
    output logic [CNT_W-1:0] rd_count
);
    logic [CNT_W-1:0]  mem [STORE_DEPTH];
    logic [CNT_W-1:0]  rdata_reg, base, new_cnt, wr_data_reg;
    logic [ADDR_W-1:0] clr_cnt_reg, st_addr_reg, wr_addr_reg, rd_addr;
    logic              clearing_reg, st_valid_reg, wr_valid_reg, rd_done_reg, rd_zero_reg;

    assign rd_addr = rd_req.valid ? rd_req.addr : upd.addr;
    // A write in the previous cycle is not yet seen by the read just made
    assign base    = (wr_valid_reg && (wr_addr_reg == st_addr_reg)) ? wr_data_reg : rdata_reg;
    assign new_cnt = (base == COUNT_MAX) ? base : base + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            st_valid_reg <= 1'b0;
            wr_valid_reg <= 1'b0;
            rd_done_reg  <= 1'b0;
        end else begin
            if (clearing_reg) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == {ADDR_W{1'b1}}) begin
                    clearing_reg <= 1'b0;
                end
            end
            st_valid_reg <= upd.valid;
            wr_valid_reg <= st_valid_reg;
            rd_done_reg  <= rd_req.valid;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg   <= mem[rd_addr];
        st_addr_reg <= upd.addr;
        wr_addr_reg <= st_addr_reg;
        wr_data_reg <= new_cnt;
        rd_zero_reg <= rd_req.out_of_range;
        if (clearing_reg) begin
            mem[clr_cnt_reg] <= '0;
        end else if (st_valid_reg) begin
            mem[st_addr_reg] <= new_cnt;
        end
    end

    assign clearing = clearing_reg;
    assign rd_done  = rd_done_reg;
    assign rd_count = rd_zero_reg ? '0 : rdata_reg;
endmodule
`default_nettype wire

// ===== design/periodic_image_density_histogram.sv =====
// Read path: a read item's result is registered in the store's read register and then in
// the result register after it leaves the input queue; adds give no result.
// Throughput: an add is taken from the queue and then gives one periodic image a cycle
// until all 125 images are issued; a read waits until the binning pipeline (up to the
// counter write) has drained and the result register is free.
// Reset: synchronous; afterwards a clearing pass zeroes all 65536 counts,
// with s_ready low. Configuration registers reset to zero.
// Depends on pidh_pkg, pidh_front, pidh_back, pidh_store.
`default_nettype none
module periodic_image_density_histogram
    import pidh_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [62:0]        cfg_wdata,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_cmd,
    input  wire logic signed [23:0] s_frac_x,
    input  wire logic signed [23:0] s_frac_y,
    input  wire logic signed [23:0] s_frac_z,
    input  wire logic [1:0]         s_atom_kind,
    input  wire logic [15:0]        s_read_index,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [23:0]             m_bin_count
);
    cfg_t             cfg_reg;
    item_t            in_item, head_item;
    logic             head_valid, pop, clearing, rd_done, m_valid_reg;
    logic [CNT_W-1:0] rd_count, m_bin_count_reg;
    rd_req_t          rd_req;
    upd_t             upd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_LAT_A:     cfg_reg.lat_a    <= cfg_wdata;
                CFG_LAT_B:     cfg_reg.lat_b    <= cfg_wdata;
                CFG_LAT_C:     cfg_reg.lat_c    <= cfg_wdata;
                CFG_WIN_LOW:   cfg_reg.win_low  <= cfg_wdata;
                CFG_WIN_HIGH:  cfg_reg.win_high <= cfg_wdata;
                CFG_BIN_SCALE: cfg_reg.scale    <= cfg_wdata[59:0];
                default: ;
            endcase
        end
    end

    assign in_item.cmd        = cmd_t'(s_cmd);
    assign in_item.frac_x     = s_frac_x;
    assign in_item.frac_y     = s_frac_y;
    assign in_item.frac_z     = s_frac_z;
    assign in_item.atom_kind  = s_atom_kind;
    assign in_item.read_index = s_read_index;

    pidh_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .enable     (!clearing),
        .push_valid (s_valid),
        .push_ready (s_ready),
        .push_item  (in_item),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop)
    );

    pidh_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .out_busy   (m_valid_reg || rd_done),
        .rd_req     (rd_req),
        .upd        (upd)
    );

    pidh_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .upd      (upd),
        .rd_req   (rd_req),
        .clearing (clearing),
        .rd_done  (rd_done),
        .rd_count (rd_count)
    );

    // Hold the result until the consumer takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (rd_done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_done) begin
            m_bin_count_reg <= rd_count;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_bin_count = m_bin_count_reg;
endmodule
`default_nettype wire

// ===== design/pidh_checker.sv =====
// Port-level checks on the histogram top level, attached by bind.
// Depends on periodic_image_density_histogram.
`default_nettype none
module pidh_port_checks (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [23:0] m_bin_count
);
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_bin_count)) else $error("result changed while stalled");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready) else $error("busy right after reset");

    a_clear_pass: assert property (@(posedge aclk)
        !aresetn |=> ##1 !s_ready && !m_valid) else $error("items taken during clearing");
endmodule

bind periodic_image_density_histogram pidh_port_checks u_pidh_port_checks (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_bin_count (m_bin_count)
);
`default_nettype wire

// ===== test/pidh_checker.sv =====
// Checker for the periodic-image density histogram: watches the configuration port and both
// channels, keeps its own copy of the counts and compares every returned bin count.
// Depends on pidh_pkg.
`timescale 1ns / 1ps
module pidh_checker
    import pidh_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [62:0]        cfg_wdata,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire logic               s_cmd,
    input  wire logic signed [23:0] s_frac_x,
    input  wire logic signed [23:0] s_frac_y,
    input  wire logic signed [23:0] s_frac_z,
    input  wire logic [1:0]         s_atom_kind,
    input  wire logic [15:0]        s_read_index,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire logic [23:0]        m_bin_count,
    output int                      errors,
    output int                      pending
);
    logic [CNT_W-1:0] counts [STORE_DEPTH];
    logic [CNT_W-1:0] expected_counts [$];
    cfg_t             regs;

    function automatic longint comp21(logic [62:0] r, int axis);
        logic signed [20:0] v;
        v = r[21*axis +: 21];
        return longint'(v);
    endfunction

    task automatic bin_atom(longint fx, longint fy, longint fz, int kind);
        longint lat [3][3];
        longint lo [3];
        longint hi [3];
        longint sc [3];
        longint dims [3];
        longint f [3];
        longint bin [3];
        longint acc;
        longint pos;
        int     addr;
        bit     in_win;
        dims = '{DIM_X, DIM_Y, DIM_Z};
        for (int a = 0; a < 3; a++) begin
            lat[0][a] = comp21(regs.lat_a, a);
            lat[1][a] = comp21(regs.lat_b, a);
            lat[2][a] = comp21(regs.lat_c, a);
            lo[a] = comp21(regs.win_low, a);
            hi[a] = comp21(regs.win_high, a);
            sc[a] = longint'(regs.scale[20*a +: 20]);
        end
        for (int ix = -IMAGE_REACH; ix <= IMAGE_REACH; ix++)
            for (int iy = -IMAGE_REACH; iy <= IMAGE_REACH; iy++)
                for (int iz = -IMAGE_REACH; iz <= IMAGE_REACH; iz++) begin
                    f[0] = fx + longint'(ix) * (1 << 20);
                    f[1] = fy + longint'(iy) * (1 << 20);
                    f[2] = fz + longint'(iz) * (1 << 20);
                    in_win = 1;
                    for (int a = 0; a < 3 && in_win; a++) begin
                        acc = f[0] * lat[0][a] + f[1] * lat[1][a] + f[2] * lat[2][a];
                        pos = acc >>> 22;
                        if (pos < lo[a] || pos > hi[a])
                            in_win = 0;
                        else begin
                            bin[a] = ((pos - lo[a]) * sc[a]) >> 22;
                            if (bin[a] >= dims[a])
                                bin[a] = dims[a] - 1;
                        end
                    end
                    if (in_win) begin
                        addr = kind * PLANE + int'((bin[0] * DIM_Y + bin[1]) * DIM_Z + bin[2]);
                        if (addr < STORE_DEPTH && counts[addr] != COUNT_MAX)
                            counts[addr] = counts[addr] + 1'b1;
                    end
                end
    endtask

    initial begin
        errors = 0;
        pending = 0;
        regs = '0;
        foreach (counts[i])
            counts[i] = '0;
    end

    // Sample mid-cycle: everything is driven at the rising edge, so this is what the
    // next edge will see.
    always @(negedge aclk) begin
        if (aresetn && cfg_we) begin
            case (cfg_index)
                CFG_LAT_A:     regs.lat_a    = cfg_wdata;
                CFG_LAT_B:     regs.lat_b    = cfg_wdata;
                CFG_LAT_C:     regs.lat_c    = cfg_wdata;
                CFG_WIN_LOW:   regs.win_low  = cfg_wdata;
                CFG_WIN_HIGH:  regs.win_high = cfg_wdata;
                CFG_BIN_SCALE: regs.scale    = cfg_wdata[59:0];
                default: ;
            endcase
        end
        if (aresetn && s_valid && s_ready) begin
            if (cmd_t'(s_cmd) == CMD_READ) begin
                if (int'(s_read_index) < TOTAL_BINS)
                    expected_counts.push_back(counts[s_read_index]);
                else
                    expected_counts.push_back('0);
            end else if (int'(s_atom_kind) < NUM_KINDS)
                bin_atom(longint'(s_frac_x), longint'(s_frac_y), longint'(s_frac_z),
                         int'(s_atom_kind));
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_counts.size() == 0) begin
                errors++;
                $display("%0t: unexpected bin count, expected none, actual %0d",
                         $time, m_bin_count);
            end else begin
                if (m_bin_count !== expected_counts[0]) begin
                    errors++;
                    $display("%0t: bin count mismatch, expected %0d, actual %0d",
                             $time, expected_counts[0], m_bin_count);
                end
                void'(expected_counts.pop_front());
            end
        end
        pending = expected_counts.size();
    end
endmodule

// ===== test/tb_periodic_image_density_histogram.sv =====
// Top of the histogram testbench: clock, reset, configuration and item stimulus, result
// stalls and the verdict. Depends on pidh_pkg, the block and pidh_checker.
`timescale 1ns / 1ps
module tb_periodic_image_density_histogram;
    import pidh_pkg::*;

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               cfg_we = 0;
    logic [2:0]         cfg_index = '0;
    logic [62:0]        cfg_wdata = '0;
    logic               s_valid = 0;
    logic               s_ready;
    logic               s_cmd = CMD_ADD;
    logic signed [23:0] s_frac_x = '0;
    logic signed [23:0] s_frac_y = '0;
    logic signed [23:0] s_frac_z = '0;
    logic [1:0]         s_atom_kind = '0;
    logic [15:0]        s_read_index = '0;
    logic               m_valid;
    logic               m_ready = 0;
    logic [23:0]        m_bin_count;
    int                 errors;
    int                 pending;
    int                 tx_idle = 0;
    int                 rx_idle = 0;
    int                 hold_len = 0;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    periodic_image_density_histogram i_dut (.*);

    pidh_checker i_checker (.*);

    // Result side: random stalls, or one long hold-off when asked.
    initial forever begin
        @(posedge aclk);
        if (hold_len > 0) begin
            m_ready <= 0;
            hold_len--;
        end else
            m_ready <= ($urandom_range(99) >= rx_idle);
    end

    initial begin
        #20ms;
        $display("tb_periodic_image_density_histogram NOT OK");
        $finish;
    end

    function automatic logic [62:0] pack21(int x, int y, int z);
        logic [20:0] a, b, c;
        a = x[20:0];
        b = y[20:0];
        c = z[20:0];
        return {c, b, a};
    endfunction

    task automatic send(cmd_t cmd, int fx, int fy, int fz, int kind, int idx);
        bit got;
        if ($urandom_range(99) < tx_idle) begin
            s_valid <= 0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle);
        end
        s_valid      <= 1;
        s_cmd        <= cmd;
        s_frac_x     <= fx[23:0];
        s_frac_y     <= fy[23:0];
        s_frac_z     <= fz[23:0];
        s_atom_kind  <= kind[1:0];
        s_read_index <= idx[15:0];
        do begin
            @(negedge aclk);
            got = s_ready;
            @(posedge aclk);
        end while (!got);
    endtask

    task automatic add_atom(int fx, int fy, int fz, int kind);
        send(CMD_ADD, fx, fy, fz, kind, $urandom);
    endtask

    task automatic read_bin(int idx);
        send(CMD_READ, $urandom, $urandom, $urandom, $urandom, idx);
    endtask

    // A read only leaves once the adds ahead of it are binned, so its answer means idle.
    task automatic drain();
        read_bin($urandom);
        s_valid <= 0;
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [62:0] data);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we    <= 0;
        @(posedge aclk);
    endtask

    task automatic set_config(int phase);
        case (phase)
            0: begin  // cubic cell of 4 units, one bin per unit
                write_reg(CFG_LAT_A, pack21(4 << 12, 0, 0));
                write_reg(CFG_LAT_B, pack21(0, 4 << 12, 0));
                write_reg(CFG_LAT_C, pack21(0, 0, 4 << 12));
                write_reg(CFG_WIN_LOW, pack21(0, 0, 0));
                write_reg(CFG_WIN_HIGH, pack21(4 << 10, 4 << 10, 4 << 10));
                write_reg(CFG_BIN_SCALE, 63'({20'd4096, 20'd4096, 20'd4096}));
            end
            1: begin  // skewed cell, wide window, fine bins so the top bins clamp
                write_reg(CFG_LAT_A, pack21(3 << 12, 700, -300));
                write_reg(CFG_LAT_B, pack21(-900, 5 << 12, 400));
                write_reg(CFG_LAT_C, pack21(250, -600, 2 << 12));
                write_reg(CFG_WIN_LOW, pack21(-2 << 10, -3 << 10, -1 << 10));
                write_reg(CFG_WIN_HIGH, pack21(9 << 10, 12 << 10, 6 << 10));
                write_reg(CFG_BIN_SCALE, 63'({20'd40000, 20'd20000, 20'd13000}));
            end
            2: begin  // window and scale at their limits; lattice fields at -1, 1 or their limits
                write_reg(CFG_LAT_A, {63{1'b1}});
                write_reg(CFG_LAT_B, pack21(-(1 << 20), (1 << 20) - 1, 1));
                write_reg(CFG_LAT_C, {63{1'b1}});
                write_reg(CFG_WIN_LOW, pack21(-(1 << 20), -(1 << 20), -(1 << 20)));
                write_reg(CFG_WIN_HIGH, pack21((1 << 20) - 1, (1 << 20) - 1, (1 << 20) - 1));
                write_reg(CFG_BIN_SCALE, 63'({60{1'b1}}));
            end
            default: begin  // empty window on y: nothing is counted
                write_reg(CFG_LAT_A, pack21(4 << 12, 0, 0));
                write_reg(CFG_LAT_B, pack21(0, 4 << 12, 0));
                write_reg(CFG_LAT_C, pack21(0, 0, 4 << 12));
                write_reg(CFG_WIN_LOW, pack21(0, 5 << 10, 0));
                write_reg(CFG_WIN_HIGH, pack21(4 << 10, 1 << 10, 4 << 10));
                write_reg(CFG_BIN_SCALE, 63'({20'd4096, 20'd4096, 20'd4096}));
            end
        endcase
    endtask

    function automatic int pick_frac();
        if ($urandom_range(9) == 0)
            return $urandom;
        return $urandom_range(0, (1 << 20) - 1);
    endfunction

    // Half of the picks are bins near the origin of a plane, where the counts pile up.
    function automatic int pick_index();
        if ($urandom_range(1))
            return $urandom_range(0, 65535);
        return ($urandom_range(3) << 14) | ($urandom_range(3) << 9) | ($urandom_range(3) << 4)
             | $urandom_range(3);
    endfunction

    initial begin
        int n;
        repeat (7) @(posedge aclk);
        aresetn <= 1;

        // Reset configuration: every image lands at the origin, bin 0 of its plane.
        add_atom(0, 0, 0, 0);
        add_atom(8388607, 8388607, 8388607, 1);
        add_atom(-8388608, -8388608, -8388608, 2);
        add_atom(12345, -54321, 999, 3);
        add_atom(0, 0, 0, 0);
        read_bin(0);
        read_bin(16384);
        read_bin(32768);
        read_bin(49152);
        read_bin(65535);
        read_bin(1);
        drain();

        set_config(0);
        add_atom(0, 0, 0, 1);
        add_atom((1 << 20) - 1, (1 << 20) - 1, (1 << 20) - 1, 1);
        add_atom(1 << 19, 1 << 18, 3 << 18, 2);
        add_atom(-(1 << 19), -1, 1, 3);
        read_bin(16384);
        read_bin(16384 | (3 << 9) | (3 << 4) | 3);
        read_bin(32768 | (2 << 9) | (1 << 4) | 3);
        read_bin(49152 | (2 << 9) | (3 << 4));
        read_bin(49152 | (1 << 4));
        drain();

        n = 0;
        for (int phase = 0; phase < 4; phase++) begin
            set_config(phase);
            for (int i = 0; i < 450; i++) begin
                if (n < 600) begin
                    tx_idle = 22;
                    rx_idle = 55;
                end else if (n < 1200) begin
                    tx_idle = 55;
                    rx_idle = 22;
                end else begin
                    tx_idle = 0;
                    rx_idle = 0;
                end
                if (i == 200) begin
                    // Hold the result side off and keep offering reads until the input stalls.
                    hold_len = 300;
                    for (int k = 0; k < 12; k++)
                        read_bin(pick_index());
                end
                if ($urandom_range(99) < 55)
                    add_atom(pick_frac(), pick_frac(), pick_frac(), $urandom_range(3));
                else
                    read_bin(pick_index());
                n++;
            end
            drain();
        end

        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("tb_periodic_image_density_histogram OK");
        else
            $display("tb_periodic_image_density_histogram NOT OK");
        $finish;
    end
endmodule
